// ===== hw/rtl/idl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package idl_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = 8;

    localparam logic [2:0] CMD_ADD_FRONT    = 3'd0;
    localparam logic [2:0] CMD_ADD_BACK     = 3'd1;
    localparam logic [2:0] CMD_ADD_AT       = 3'd2;
    localparam logic [2:0] CMD_REMOVE_FRONT = 3'd3;
    localparam logic [2:0] CMD_REMOVE_BACK  = 3'd4;
    localparam logic [2:0] CMD_REMOVE_AT    = 3'd5;
    localparam logic [2:0] CMD_DUMP         = 3'd6;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BADIDX = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [1:0] STATUS_FULL   = 2'd3;

    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_ROTATE = 2'd3;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        value_t           data;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_deque_list.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata (low bit up)                              tuser    tlast
// s_axis    in   index[6:0], value[38:7], zero pad[39]           cmd      -
// m_axis    out  status[1:0], count[8:2], position[14:9],         is_dump  last
//                entry_value[46:15], zero pad[47]
//
// one transaction per cycle for add and remove while the output is not stalled: the cell chain shifts as a whole
// a dump holds the input from the accepting cycle until its last result, with one rotation
// of the chain per result
// a new transaction is taken only when the output register is empty or drains that cycle
// output stalls hold the dump rotation; async active-low reset empties the list

module indexed_deque_list (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // index, value
    input  wire  [2:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status, count, position, entry_value
    output logic [0:0]  m_axis_tuser,   // is_dump
    output logic        m_axis_tlast
);
    import idl_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic             state_reg,    state_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [IDX_W-1:0] dump_pos_reg, dump_pos_next;
    logic             m_valid_reg,  m_valid_next;
    logic [1:0]       status_reg,   status_next;
    logic [6:0]       cnt_out_reg,  cnt_out_next;
    logic [5:0]       position_reg, position_next;
    logic [31:0]      evalue_reg,   evalue_next;
    logic             is_dump_reg,  is_dump_next;
    logic             last_reg,     last_next;

    ctrl_t ctrl;
    value_t cell_val [CAPACITY];

    logic [2:0]             in_cmd;
    logic [6:0]             in_index;
    logic [31:0]            in_value;
    logic [CMP_W-1:0]       idx_w;
    logic [CMP_W-1:0]       cnt_w;
    logic                   out_free;
    logic                   in_fire;
    logic                   dump_last;
    logic signed [VALUE_WIDTH-1:0] head_s;
    logic signed [63:0]     head_wide;

    assign in_cmd   = s_axis_tuser;
    assign in_index = s_axis_tdata[6:0];
    assign in_value = s_axis_tdata[38:7];
    assign idx_w    = CMP_W'(in_index);
    assign cnt_w    = CMP_W'(count_reg);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign head_s    = cell_val[0];
    assign head_wide = 64'(head_s);
    assign dump_last = (CNT_W'(dump_pos_reg) + CNT_W'(1)) == count_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            value_t left_v;
            value_t right_v;
            if (gi == 0)
            begin : g_first
                assign left_v = '0;
            end
            else
            begin : g_mid_l
                assign left_v = cell_val[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_v = '0;
            end
            else
            begin : g_mid_r
                assign right_v = cell_val[gi+1];
            end
            idl_cell u_cell (
                .clk       (clk),
                .cell_idx  (IDX_W'(gi)),
                .ctrl      (ctrl),
                .left_val  (left_v),
                .right_val (right_v),
                .wrap_val  (cell_val[0]),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_pos_next = dump_pos_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        status_next   = status_reg;
        cnt_out_next  = cnt_out_reg;
        position_next = position_reg;
        evalue_next   = evalue_reg;
        is_dump_next  = is_dump_reg;
        last_next     = last_reg;

        ctrl.mode = MODE_HOLD;
        ctrl.pos  = '0;
        ctrl.cnt  = count_reg;
        ctrl.data = VALUE_WIDTH'($unsigned(in_value));

        if (in_fire)
        begin
            status_next   = STATUS_OK;
            position_next = '0;
            evalue_next   = '0;
            is_dump_next  = 1'b0;
            last_next     = 1'b1;
            m_valid_next  = 1'b1;
            case (in_cmd)
                CMD_ADD_FRONT, CMD_ADD_BACK, CMD_ADD_AT:
                begin
                    if (in_cmd == CMD_ADD_FRONT)
                    begin
                        ctrl.pos = '0;
                    end
                    else if (in_cmd == CMD_ADD_BACK)
                    begin
                        ctrl.pos = count_reg;
                    end
                    else
                    begin
                        ctrl.pos = CNT_W'(in_index);
                    end
                    if (in_cmd == CMD_ADD_AT && idx_w > cnt_w)
                    begin
                        status_next = STATUS_BADIDX;
                    end
                    else if (cnt_w >= CMP_W'(CAPACITY))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.mode  = MODE_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_REMOVE_FRONT, CMD_REMOVE_BACK:
                begin
                    ctrl.pos = (in_cmd == CMD_REMOVE_FRONT) ? '0 : count_reg - CNT_W'(1);
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctrl.mode  = MODE_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_REMOVE_AT:
                begin
                    ctrl.pos = CNT_W'(in_index);
                    if (idx_w >= cnt_w)
                    begin
                        status_next = STATUS_BADIDX;
                    end
                    else
                    begin
                        ctrl.mode  = MODE_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_DUMP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        m_valid_next  = 1'b0;
                        state_next    = ST_DUMP;
                        dump_pos_next = '0;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
            cnt_out_next = 7'(count_next);
        end
        else if (state_reg == ST_DUMP && out_free)
        begin
            ctrl.mode     = MODE_ROTATE;
            m_valid_next  = 1'b1;
            status_next   = STATUS_OK;
            cnt_out_next  = 7'(count_reg);
            position_next = 6'(dump_pos_reg);
            evalue_next   = head_wide[31:0];
            is_dump_next  = 1'b1;
            last_next     = dump_last;
            dump_pos_next = dump_pos_reg + IDX_W'(1);
            if (dump_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            dump_pos_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_pos_reg <= dump_pos_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        cnt_out_reg  <= cnt_out_next;
        position_reg <= position_next;
        evalue_reg   <= evalue_next;
        is_dump_reg  <= is_dump_next;
        last_reg     <= last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, evalue_reg, position_reg, cnt_out_reg, status_reg};
    assign m_axis_tuser  = is_dump_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/idl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module idl_cell (
    input  wire                       clk,
    input  wire  [idl_pkg::IDX_W-1:0] cell_idx,
    input  wire  idl_pkg::ctrl_t      ctrl,
    input  wire  idl_pkg::value_t     left_val,
    input  wire  idl_pkg::value_t     right_val,
    input  wire  idl_pkg::value_t     wrap_val,
    output idl_pkg::value_t           val
);
    import idl_pkg::*;

    value_t           val_reg;
    value_t           val_next;
    logic [CNT_W-1:0] my_idx;
    logic [CNT_W-1:0] my_idx_p1;

    assign my_idx    = CNT_W'(cell_idx);
    assign my_idx_p1 = my_idx + CNT_W'(1);
    assign val       = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (ctrl.mode)
            MODE_INSERT:
            begin
                if (my_idx == ctrl.pos)
                begin
                    val_next = ctrl.data;
                end
                else if (my_idx > ctrl.pos)
                begin
                    val_next = left_val;
                end
            end
            MODE_REMOVE:
            begin
                if (my_idx >= ctrl.pos)
                begin
                    val_next = right_val;
                end
            end
            MODE_ROTATE:
            begin
                if (my_idx_p1 == ctrl.cnt)
                begin
                    val_next = wrap_val;
                end
                else if (my_idx < ctrl.cnt)
                begin
                    val_next = right_val;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire
